// File: rtl/mlpf_pkg.sv
// ----------------------------------------------------------------------------
// mlpf_pkg
// Shared types, sizes and codes of the multilevel priority fifo unit.
// ----------------------------------------------------------------------------
package mlpf_pkg;

   localparam int LEVELS      = 8;
   localparam int LEVEL_DEPTH = 16;

   localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
   localparam int ENTRIES = LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LIM_W   = ($clog2(LEVELS + 1) > 4) ? $clog2(LEVELS + 1) : 4;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVELS_IN_USE = '0;
   localparam logic [3:0] LEVELS_IN_USE_RESET = 4'd8;

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_EMPTY        = 2'd1,
      ST_BAD_PRIORITY = 2'd2,
      ST_FULL         = 2'd3
   } status_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] value;
      logic [2:0]         priority_req;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      logic [1:0]         status;
   } rsp_payload_type;

   // request from the pointer logic to the entry store
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       wdata;
   } mem_req_type;

endpackage

// File: rtl/mlpf_store.sv
// ----------------------------------------------------------------------------
// mlpf_store
// Entry store: one ring of words per level, one access per cycle, read data
// registered.
// ----------------------------------------------------------------------------
module mlpf_store (
   input  logic                 clock,
   input  mlpf_pkg::mem_req_type mem_req,
   output logic [31:0]          rd_data
);

   logic [31:0] mem_ff [mlpf_pkg::ENTRIES];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.addr] <= mem_req.wdata;
      end
      // holds while the result waits downstream
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mlpf_ctrl.sv
// ----------------------------------------------------------------------------
// mlpf_ctrl
// Per-level head, tail and fill count; admission checks, priority select
// and store addressing for one transaction per cycle while process is high.
// ----------------------------------------------------------------------------
module mlpf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          process,
   input  mlpf_pkg::req_payload_type     item,
   input  logic [mlpf_pkg::LIM_W-1:0]    lim,
   output mlpf_pkg::mem_req_type         mem_req,
   output mlpf_pkg::status_type          status,
   output logic                          deq_ok
);

   logic [mlpf_pkg::PTR_W-1:0] head_ff  [mlpf_pkg::LEVELS];
   logic [mlpf_pkg::PTR_W-1:0] head_in  [mlpf_pkg::LEVELS];
   logic [mlpf_pkg::PTR_W-1:0] tail_ff  [mlpf_pkg::LEVELS];
   logic [mlpf_pkg::PTR_W-1:0] tail_in  [mlpf_pkg::LEVELS];
   logic [mlpf_pkg::CNT_W-1:0] count_ff [mlpf_pkg::LEVELS];
   logic [mlpf_pkg::CNT_W-1:0] count_in [mlpf_pkg::LEVELS];

   logic [mlpf_pkg::LVL_W-1:0] enq_lvl;
   logic [mlpf_pkg::LVL_W-1:0] deq_lvl;
   logic                       prio_ok;
   logic                       lvl_full;
   logic                       deq_found;
   logic                       enq_ok;
   logic [mlpf_pkg::ADDR_W-1:0] enq_addr;
   logic [mlpf_pkg::ADDR_W-1:0] deq_addr;

   function automatic logic [mlpf_pkg::PTR_W-1:0] ring_next(
      input logic [mlpf_pkg::PTR_W-1:0] pos
   );
      if (pos == mlpf_pkg::PTR_W'(mlpf_pkg::LEVEL_DEPTH - 1)) begin
         return '0;
      end
      return pos + 1'b1;
   endfunction

   assign enq_lvl  = mlpf_pkg::LVL_W'(item.priority_req);
   assign prio_ok  = mlpf_pkg::LIM_W'(item.priority_req) < lim;
   assign lvl_full = count_ff[enq_lvl] >= mlpf_pkg::CNT_W'(mlpf_pkg::LEVEL_DEPTH);

   // lowest-numbered non-empty level in use
   always_comb begin
      deq_found = 1'b0;
      deq_lvl   = '0;
      for (int i = mlpf_pkg::LEVELS - 1; i >= 0; i--) begin
         if ((count_ff[i] != '0) && (mlpf_pkg::LIM_W'(i) < lim)) begin
            deq_found = 1'b1;
            deq_lvl   = mlpf_pkg::LVL_W'(i);
         end
      end
   end

   assign enq_addr = mlpf_pkg::ADDR_W'(enq_lvl * mlpf_pkg::LEVEL_DEPTH)
                   + mlpf_pkg::ADDR_W'(tail_ff[enq_lvl]);
   assign deq_addr = mlpf_pkg::ADDR_W'(deq_lvl * mlpf_pkg::LEVEL_DEPTH)
                   + mlpf_pkg::ADDR_W'(head_ff[deq_lvl]);

   assign enq_ok = (item.func == mlpf_pkg::FUNC_ENQUEUE) && prio_ok && !lvl_full;
   assign deq_ok = (item.func == mlpf_pkg::FUNC_DEQUEUE) && deq_found;

   always_comb begin
      if (item.func == mlpf_pkg::FUNC_ENQUEUE) begin
         if (!prio_ok) begin
            status = mlpf_pkg::ST_BAD_PRIORITY;
         end else if (lvl_full) begin
            status = mlpf_pkg::ST_FULL;
         end else begin
            status = mlpf_pkg::ST_OK;
         end
      end else begin
         status = deq_found ? mlpf_pkg::ST_OK : mlpf_pkg::ST_EMPTY;
      end
   end

   always_comb begin
      mem_req.wr_en = process && enq_ok;
      mem_req.rd_en = process && deq_ok;
      mem_req.addr  = (item.func == mlpf_pkg::FUNC_ENQUEUE) ? enq_addr : deq_addr;
      mem_req.wdata = item.value;
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (process && enq_ok) begin
         tail_in[enq_lvl]  = ring_next(tail_ff[enq_lvl]);
         count_in[enq_lvl] = count_ff[enq_lvl] + 1'b1;
      end
      if (process && deq_ok) begin
         head_in[deq_lvl]  = ring_next(head_ff[deq_lvl]);
         count_in[deq_lvl] = count_ff[deq_lvl] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mlpf_pkg::LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/multilevel_priority_fifo_unit.sv
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_unit
// Strict-priority queue with one ring buffer per level, level 0 most urgent.
// ----------------------------------------------------------------------------
// Each request transaction (enqueue or dequeue) gives one response
// transaction. A request is captured in an input register and decided once
// the output register is free. At the end of that cycle the level pointers,
// the entry store and the output register are all updated together, and the
// response is presented from the output register. A new request is taken
// every cycle unless a waiting response holds the output register.
// The input and output registers set this timing; the single-port entry
// store with its registered read data serves the one access that each
// transaction needs. levels_in_use (byte address 0, reset 8) limits the
// levels that take enqueues and are searched on dequeue; values above the
// number of levels act as all levels.
module multilevel_priority_fifo_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mlpf_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mlpf_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mlpf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [mlpf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mlpf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic                      in_valid_ff;
   mlpf_pkg::req_payload_type in_item_ff;
   logic                      out_valid_ff;
   logic                      out_deq_ok_ff;
   mlpf_pkg::status_type      out_status_ff;
   logic [3:0]                levels_ff;

   logic                      out_free;
   logic                      process;
   logic [mlpf_pkg::LIM_W-1:0] lim;
   mlpf_pkg::mem_req_type     mem_req;
   mlpf_pkg::status_type      status;
   logic                      deq_ok;
   logic [31:0]               rd_data;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // saturate the register to the number of levels built
   assign lim = (mlpf_pkg::LIM_W'(levels_ff) > mlpf_pkg::LIM_W'(mlpf_pkg::LEVELS))
              ? mlpf_pkg::LIM_W'(mlpf_pkg::LEVELS) : mlpf_pkg::LIM_W'(levels_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         out_status_ff <= status;
         out_deq_ok_ff <= deq_ok;
      end
   end

   mlpf_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .process (process),
      .item    (in_item_ff),
      .lim     (lim),
      .mem_req (mem_req),
      .status  (status),
      .deq_ok  (deq_ok)
   );

   mlpf_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_valid             = out_valid_ff;
   assign rsp_payload.value_out = out_deq_ok_ff ? rd_data : '0;
   assign rsp_payload.status    = out_status_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= mlpf_pkg::LEVELS_IN_USE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr == mlpf_pkg::CSR_LEVELS_IN_USE)) begin
         levels_ff <= csr_pwdata[3:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == mlpf_pkg::CSR_LEVELS_IN_USE)
                     ? {{(mlpf_pkg::CSR_DATA_W - 4){1'b0}}, levels_ff} : '0;

endmodule
